// ===== src/dlb_pkg.sv =====
// package for the discrete log core: widths, multiplier operand selects, and the
// command and status structs between controller and datapath
// no dependencies
package dlb_pkg;

  localparam int MOD_BITS    = 20;
  localparam int TABLE_DEPTH = 1024;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int N_W     = (MOD_BITS + 1) / 2 + 1;
  localparam int CNT_W   = (N_W > ADDR_W + 1) ? N_W : ADDR_W + 1;
  localparam int SQ_W    = MOD_BITS + 2;
  localparam int SQ_TOP  = 2 * ((MOD_BITS - 1) / 2);
  localparam int RED_W   = MOD_BITS + 2;
  localparam int MCNT_W  = $clog2(MOD_BITS + 1);
  localparam int SEL_W   = 3;

  // multiplier operand / destination selects
  localparam logic [SEL_W-1:0] SEL_RED_A     = 3'd0;
  localparam logic [SEL_W-1:0] SEL_RED_B     = 3'd1;
  localparam logic [SEL_W-1:0] SEL_GIANT     = 3'd2;
  localparam logic [SEL_W-1:0] SEL_POWER     = 3'd3;
  localparam logic [SEL_W-1:0] SEL_BABY_CUR  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_BABY_NEXT = 3'd5;

  typedef struct packed {
    logic             load;
    logic             sqrt_start;
    logic             mul_start;
    logic [SEL_W-1:0] mul_sel;
    logic             giant_init;
    logic             power_init;
    logic             baby_init;
    logic             k_clr;
    logic             k_inc;
    logic             tbl_wr;
    logic             i_clr;
    logic             i_inc;
    logic             tbl_rd;
    logic             j_clr;
    logic             j_inc;
    logic             res_set;
    logic             res_found;
    logic             post;
  } dlb_cmd_t;

  typedef struct packed {
    logic m_small;
    logic n_big;
    logic sqrt_busy;
    logic mul_busy;
    logic k_last;
    logic i_last;
    logic j_last;
    logic hit;
    logic ans_ok;
    logic out_free;
  } dlb_stat_t;

endpackage

// ===== src/dlb_mul.sv =====
// bit-serial modular multiplier: p = x * y mod m, one bit of x per cycle
// depends on dlb_pkg
module dlb_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dlb_pkg::MOD_BITS-1:0] x,
  input  logic [dlb_pkg::MOD_BITS-1:0] y,
  input  logic [dlb_pkg::MOD_BITS-1:0] m,
  output logic                         busy,
  output logic                         done,
  output logic [dlb_pkg::MOD_BITS-1:0] p
);

  logic                          busy_r, busy_nxt;
  logic [dlb_pkg::MCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [dlb_pkg::MOD_BITS-1:0]  x_r, x_nxt;
  logic [dlb_pkg::MOD_BITS-1:0]  y_r, y_nxt;
  logic [dlb_pkg::RED_W-1:0]     acc_r, acc_nxt;
  logic [dlb_pkg::RED_W-1:0]     t0, t1, t2, m_ext;

  assign m_ext = dlb_pkg::RED_W'(m);

  always_comb begin
    t0 = {acc_r[dlb_pkg::RED_W-2:0], 1'b0}
         + (x_r[dlb_pkg::MOD_BITS-1] ? dlb_pkg::RED_W'(y_r) : '0);
    t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
    t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = t2;
      x_nxt   = {x_r[dlb_pkg::MOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == dlb_pkg::MCNT_W'(dlb_pkg::MOD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign p    = t2[dlb_pkg::MOD_BITS-1:0];

endmodule

// ===== src/dlb_datapath.sv =====
// datapath: operand registers, integer square root, giant step table,
// search counters and output word register
// depends on dlb_pkg and dlb_mul
module dlb_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dlb_pkg::dlb_cmd_t            cmd,
  output dlb_pkg::dlb_stat_t           stat,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_base,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_target,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_modulus,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [dlb_pkg::MOD_BITS-1:0] out_log_value
);

  localparam int MB = dlb_pkg::MOD_BITS;
  localparam int CW = dlb_pkg::CNT_W;

  logic [MB-1:0] a_r, b_r, m_r, giant_r, rp_r, baby_r, cur_r;
  logic [dlb_pkg::SEL_W-1:0] sel_r;

  // square root
  logic                   sq_busy_r;
  logic [dlb_pkg::SQ_W-1:0] sv_r, sr_r, sbit_r, sum;

  logic [CW-1:0] k_r, i_r, j_r, n;
  logic [MB-1:0] mem [dlb_pkg::TABLE_DEPTH];
  logic [MB-1:0] rd_q;

  logic [2*CW-1:0] ans;
  logic            res_found_r;
  logic [MB-1:0]   res_log_r;
  logic            out_valid_r, out_found_r;
  logic [MB-1:0]   out_log_r;

  logic [MB-1:0] mx, my, mp;
  logic          m_busy, m_done;

  always_comb begin
    case (cmd.mul_sel)
      dlb_pkg::SEL_RED_A:     begin mx = a_r;     my = MB'(1);  end
      dlb_pkg::SEL_RED_B:     begin mx = b_r;     my = MB'(1);  end
      dlb_pkg::SEL_GIANT:     begin mx = giant_r; my = a_r;     end
      dlb_pkg::SEL_POWER:     begin mx = rp_r;    my = giant_r; end
      dlb_pkg::SEL_BABY_CUR:  begin mx = baby_r;  my = b_r;     end
      dlb_pkg::SEL_BABY_NEXT: begin mx = baby_r;  my = a_r;     end
      default:                begin mx = baby_r;  my = a_r;     end
    endcase
  end

  dlb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .m     (m_r),
    .busy  (m_busy),
    .done  (m_done),
    .p     (mp)
  );

  assign sum = sr_r + sbit_r;
  assign n   = CW'(sr_r[dlb_pkg::N_W-1:0]) + 1'b1;
  assign ans = (2*CW)'(i_r) * (2*CW)'(n) - (2*CW)'(j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sqrt_start) begin
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r && sbit_r[dlb_pkg::SQ_W-1:2] == '0) begin
        sq_busy_r <= 1'b0;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_base;
      b_r <= in_target;
      m_r <= in_modulus;
    end
    if (cmd.mul_start) sel_r <= cmd.mul_sel;
    if (m_done) begin
      case (sel_r)
        dlb_pkg::SEL_RED_A:     a_r     <= mp;
        dlb_pkg::SEL_RED_B:     b_r     <= mp;
        dlb_pkg::SEL_GIANT:     giant_r <= mp;
        dlb_pkg::SEL_POWER:     rp_r    <= mp;
        dlb_pkg::SEL_BABY_CUR:  cur_r   <= mp;
        dlb_pkg::SEL_BABY_NEXT: baby_r  <= mp;
        default:                baby_r  <= mp;
      endcase
    end
    if (cmd.giant_init) giant_r <= MB'(1);
    if (cmd.power_init) rp_r    <= MB'(1);
    if (cmd.baby_init)  baby_r  <= MB'(1);

    if (cmd.sqrt_start) begin
      sv_r   <= dlb_pkg::SQ_W'(m_r);
      sr_r   <= '0;
      sbit_r <= dlb_pkg::SQ_W'(1) << dlb_pkg::SQ_TOP;
    end else if (sq_busy_r) begin
      if (sv_r >= sum) begin
        sv_r <= sv_r - sum;
        sr_r <= (sr_r >> 1) + sbit_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end

    if (cmd.k_clr) k_r <= '0;
    else if (cmd.tbl_wr || cmd.k_inc) k_r <= k_r + 1'b1;
    if (cmd.i_clr) i_r <= CW'(1);
    else if (cmd.i_inc) i_r <= i_r + 1'b1;
    if (cmd.j_clr) j_r <= '0;
    else if (cmd.j_inc) j_r <= j_r + 1'b1;

    if (cmd.res_set) begin
      res_found_r <= cmd.res_found;
      res_log_r   <= cmd.res_found ? ans[MB-1:0] : '0;
    end
    if (cmd.post) begin
      out_found_r <= res_found_r;
      out_log_r   <= res_log_r;
    end
  end

  // giant step table
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) mem[k_r[dlb_pkg::ADDR_W-1:0]] <= rp_r;
    if (cmd.tbl_rd) begin
      rd_q <= mem[dlb_pkg::ADDR_W'(i_r - 1'b1)];
    end
  end

  always_comb begin
    stat.m_small   = m_r < MB'(2);
    stat.n_big     = n > CW'(dlb_pkg::TABLE_DEPTH);
    stat.sqrt_busy = sq_busy_r;
    stat.mul_busy  = m_busy;
    stat.k_last    = (k_r + 1'b1) == n;
    stat.i_last    = i_r == n;
    stat.j_last    = (j_r + 1'b1) == n;
    stat.hit       = rd_q == cur_r;
    stat.ans_ok    = ans < (2*CW)'(m_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_log_value = out_log_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !m_busy) else $error("multiplier restarted while busy");
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_wr |-> !m_busy) else $error("table write during multiply");
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_valid_r || out_ready)) else $error("output word overwritten");
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_set && cmd.res_found |=> res_log_r < m_r) else $error("log beyond modulus");

endmodule

// ===== src/dlb_ctrl.sv =====
// controller state machine sequencing root, reductions, table fill and search
// depends on dlb_pkg
module dlb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dlb_pkg::dlb_stat_t stat,
  output dlb_pkg::dlb_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_NCHK = 4'd3;
  localparam logic [3:0] S_RA   = 4'd4;
  localparam logic [3:0] S_RB   = 4'd5;
  localparam logic [3:0] S_GL   = 4'd6;
  localparam logic [3:0] S_GW   = 4'd7;
  localparam logic [3:0] S_PL   = 4'd8;
  localparam logic [3:0] S_PW   = 4'd9;
  localparam logic [3:0] S_PWR  = 4'd10;
  localparam logic [3:0] S_BC   = 4'd11;
  localparam logic [3:0] S_SA   = 4'd12;
  localparam logic [3:0] S_SC   = 4'd13;
  localparam logic [3:0] S_BN   = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.m_small) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: if (!stat.sqrt_busy) state_nxt = S_NCHK;
      S_NCHK: begin
        if (stat.n_big) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = dlb_pkg::SEL_RED_A;
          state_nxt     = S_RA;
        end
      end
      S_RA: begin
        if (!stat.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = dlb_pkg::SEL_RED_B;
          state_nxt     = S_RB;
        end
      end
      S_RB: begin
        if (!stat.mul_busy) begin
          cmd.giant_init = 1'b1;
          cmd.k_clr      = 1'b1;
          state_nxt      = S_GL;
        end
      end
      S_GL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = dlb_pkg::SEL_GIANT;
        state_nxt     = S_GW;
      end
      S_GW: begin
        if (!stat.mul_busy) begin
          // k counts giant exponent steps here, n multiplies in all
          if (stat.k_last) begin
            cmd.k_clr      = 1'b1;
            cmd.power_init = 1'b1;
            state_nxt      = S_PL;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_GL;
          end
        end
      end
      S_PL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = dlb_pkg::SEL_POWER;
        state_nxt     = S_PW;
      end
      S_PW: if (!stat.mul_busy) state_nxt = S_PWR;
      S_PWR: begin
        cmd.tbl_wr = 1'b1;
        if (stat.k_last) begin
          cmd.baby_init = 1'b1;
          cmd.j_clr     = 1'b1;
          state_nxt     = S_BC;
        end else begin
          state_nxt = S_PL;
        end
      end
      S_BC: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = dlb_pkg::SEL_BABY_CUR;
        cmd.i_clr     = 1'b1;
        state_nxt     = S_SA;
      end
      S_SA: begin
        if (!stat.mul_busy) begin
          cmd.tbl_rd = 1'b1;
          state_nxt  = S_SC;
        end
      end
      S_SC: begin
        if (stat.hit && stat.ans_ok) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.hit || stat.i_last) begin
          // first hit (smallest i) gave no usable exponent, or no i hit: next baby step, or finish after the last
          if (stat.j_last) begin
            cmd.res_set = 1'b1;
            state_nxt   = S_FIN;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = dlb_pkg::SEL_BABY_NEXT;
            state_nxt     = S_BN;
          end
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_SA;
        end
      end
      S_BN: begin
        if (!stat.mul_busy) begin
          cmd.j_inc = 1'b1;
          state_nxt = S_BC;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/discrete_log_bsgs_core.sv =====
// discrete logarithm by baby-step giant-step, one query word in, one result word out
// at most 4n+2 serial multiplies (2 reductions, n giant, n table, 2 per baby step) plus
// the table probes, n = floor(sqrt(modulus))+1; the serial table scan sets the worst case;
// one query at a time
// rst_n synchronous active low clears the controller and output valid; table needs no clear
// depends on dlb_pkg, dlb_ctrl, dlb_datapath, dlb_mul
module discrete_log_bsgs_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_base,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_target,
  input  logic [dlb_pkg::MOD_BITS-1:0] in_modulus,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [dlb_pkg::MOD_BITS-1:0] out_log_value
);

  // command and status between sequencer and datapath
  dlb_pkg::dlb_cmd_t  cmd;
  dlb_pkg::dlb_stat_t stat;

  // sequencer: root, operand reduction, giant powers, table fill, baby step search
  dlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: shared serial modular multiplier, table memory, output word register
  dlb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_base       (in_base),
    .in_target     (in_target),
    .in_modulus    (in_modulus),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_log_value (out_log_value)
  );

endmodule
